### sv/latency_stats_histogram_macros.svh
// ----------------------------------------------------------------------------
// Latency statistics histogram assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef LATENCY_STATS_HISTOGRAM_MACROS_SVH
`define LATENCY_STATS_HISTOGRAM_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent
`define LSH_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> (cons)) else $error("same-cycle check failed");

// Check that the consequent holds in the cycle after the antecedent
`define LSH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |=> (cons)) else $error("next-cycle check failed");

`endif

### sv/lsh_pkg.sv
// ----------------------------------------------------------------------------
// Latency statistics histogram package
// Command codes, bin edges, transaction payload types and queue sizing.
// ----------------------------------------------------------------------------
package lsh_pkg;

    // Histogram geometry
    localparam int NUM_BINS  = 10;
    localparam int C_BIN_W   = 4;
    localparam int C_IDX_W   = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;

    // Decoupling queue sizing
    localparam int C_Q_DEPTH = 2;
    localparam int C_Q_PTR_W = (C_Q_DEPTH > 1) ? $clog2(C_Q_DEPTH) : 1;
    localparam int C_Q_CNT_W = $clog2(C_Q_DEPTH + 1);

    // Upper bin edges in microseconds; the last bin always takes the rest
    localparam logic [31:0] C_EDGE [16] = '{
        32'd50, 32'd100, 32'd200, 32'd500, 32'd1000, 32'd2000, 32'd5000,
        32'd20000, 32'd100000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
        32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF
    };

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    // Input transaction
    typedef struct packed {
        t_cmd         command;
        logic [31:0]  sample;
        logic [3:0]   bin_select;
    } t_in;

    // Result transaction
    typedef struct packed {
        logic [31:0]  sample_count;
        logic [31:0]  min_value;
        logic [31:0]  max_value;
        logic [63:0]  sample_sum;
        logic [3:0]   bin_index;
        logic [31:0]  bin_count;
    } t_out;

    // Classified work item passed from front end to back end
    typedef struct packed {
        t_cmd                 op;
        logic [31:0]          sample;
        logic [C_BIN_W-1:0]   bin;
        logic                 bin_ok;
    } t_work;

    // Queue status seen by both ends
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

### sv/lsh_front.sv
// ----------------------------------------------------------------------------
// Latency statistics histogram front end
// Accepts input transactions, finds the histogram bin of a sample and
// pushes a classified work item into the queue.
// ----------------------------------------------------------------------------
module lsh_front (
    input  lsh_pkg::t_in     i_in,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  lsh_pkg::t_q_stat i_q_stat,
    output logic             o_push,
    output lsh_pkg::t_work   o_work
);
    import lsh_pkg::*;

    logic [C_BIN_W-1:0] w_add_bin;

    // Accept whenever the queue has room
    assign o_in_ready = !i_q_stat.full;
    assign o_push     = i_in_valid && !i_q_stat.full;

    // Find the first bin whose upper edge covers the sample
    always_comb begin
        w_add_bin = C_BIN_W'(NUM_BINS - 1);
        for (int i = NUM_BINS - 2; i >= 0; i--) begin
            if (i_in.sample <= C_EDGE[i]) begin
                w_add_bin = C_BIN_W'(i);
            end
        end
    end

    // Build the work item for the back end
    always_comb begin
        o_work.op     = i_in.command;
        o_work.sample = i_in.sample;
        o_work.bin    = '0;
        o_work.bin_ok = 1'b0;
        unique case (i_in.command)
            CMD_ADD: begin
                o_work.bin    = w_add_bin;
                o_work.bin_ok = 1'b1;
            end
            CMD_READ: begin
                o_work.bin    = i_in.bin_select;
                o_work.bin_ok = (int'(i_in.bin_select) < NUM_BINS);
            end
            CMD_CLEAR, CMD_NONE: begin
                o_work.bin    = '0;
                o_work.bin_ok = 1'b0;
            end
            default: begin
                o_work.bin    = '0;
                o_work.bin_ok = 1'b0;
            end
        endcase
    end

endmodule

### sv/lsh_queue.sv
// ----------------------------------------------------------------------------
// Latency statistics histogram work queue
// Short FIFO of classified work items between the front and back ends.
// ----------------------------------------------------------------------------
module lsh_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  lsh_pkg::t_work   i_work,
    input  logic             i_pop,
    output lsh_pkg::t_work   o_work,
    output lsh_pkg::t_q_stat o_stat
);
    import lsh_pkg::*;

    t_work                r_slot [C_Q_DEPTH];
    logic [C_Q_PTR_W-1:0] r_wr_ptr;
    logic [C_Q_PTR_W-1:0] r_rd_ptr;
    logic [C_Q_CNT_W-1:0] r_cnt;
    logic [C_Q_PTR_W-1:0] n_wr_ptr;
    logic [C_Q_PTR_W-1:0] n_rd_ptr;
    logic [C_Q_CNT_W-1:0] n_cnt;

    assign o_stat.full  = (r_cnt == C_Q_CNT_W'(C_Q_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_work       = r_slot[r_rd_ptr];

    // Advance pointers and occupancy
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == C_Q_PTR_W'(C_Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == C_Q_PTR_W'(C_Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        priority if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end else begin
            n_cnt = r_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    // Store the incoming work item
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_work;
        end
    end

endmodule

### sv/lsh_back.sv
// ----------------------------------------------------------------------------
// Latency statistics histogram back end
// Pops work items, updates count, minimum, maximum, sum and bin counters,
// and holds each result in an output register until it is taken.
// ----------------------------------------------------------------------------
module lsh_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  lsh_pkg::t_work i_work,
    input  logic           i_q_empty,
    output logic           o_pop,
    output lsh_pkg::t_out  o_out,
    output logic           o_out_valid,
    input  logic           i_out_ready
);
    import lsh_pkg::*;

    logic [31:0]        r_count;
    logic [31:0]        r_min;
    logic [31:0]        r_max;
    logic [63:0]        r_sum;
    logic [31:0]        r_bins [NUM_BINS];
    t_out               r_out;
    logic               r_out_valid;

    logic [31:0]        n_count;
    logic [31:0]        n_min;
    logic [31:0]        n_max;
    logic [63:0]        n_sum;
    t_out               n_out;
    logic [C_IDX_W-1:0] w_idx;
    logic [31:0]        w_bin_rd;
    logic [31:0]        w_bin_inc;

    // Pop when the output register is free or being drained
    assign o_pop       = !i_q_empty && (!r_out_valid || i_out_ready);
    assign o_out       = r_out;
    assign o_out_valid = r_out_valid;

    assign w_idx     = i_work.bin[C_IDX_W-1:0];
    assign w_bin_rd  = r_bins[w_idx];
    assign w_bin_inc = w_bin_rd + 32'd1;

    // Compute next statistics and the result
    always_comb begin
        n_count = r_count;
        n_min   = r_min;
        n_max   = r_max;
        n_sum   = r_sum;
        n_out.bin_index = '0;
        n_out.bin_count = '0;
        unique case (i_work.op)
            CMD_ADD: begin
                n_count = r_count + 32'd1;
                n_sum   = r_sum + {32'd0, i_work.sample};
                n_min   = (i_work.sample < r_min) ? i_work.sample : r_min;
                n_max   = (i_work.sample > r_max) ? i_work.sample : r_max;
                n_out.bin_index = i_work.bin;
                n_out.bin_count = w_bin_inc;
            end
            CMD_CLEAR: begin
                n_count = '0;
                n_min   = '1;
                n_max   = '0;
                n_sum   = '0;
            end
            CMD_READ: begin
                n_out.bin_index = i_work.bin;
                n_out.bin_count = i_work.bin_ok ? w_bin_rd : 32'd0;
            end
            CMD_NONE: begin
                n_out.bin_index = '0;
            end
            default: begin
                n_out.bin_index = '0;
            end
        endcase
        n_out.sample_count = n_count;
        n_out.min_value    = n_min;
        n_out.max_value    = n_max;
        n_out.sample_sum   = n_sum;
    end

    // Update running statistics
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_min   <= '1;
            r_max   <= '0;
            r_sum   <= '0;
        end else if (o_pop) begin
            r_count <= n_count;
            r_min   <= n_min;
            r_max   <= n_max;
            r_sum   <= n_sum;
        end
    end

    // Update histogram bins: clear all, or bump the hit bin
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_BINS; i++) begin
                r_bins[i] <= '0;
            end
        end else if (o_pop && (i_work.op == CMD_CLEAR)) begin
            for (int i = 0; i < NUM_BINS; i++) begin
                r_bins[i] <= '0;
            end
        end else if (o_pop && (i_work.op == CMD_ADD)) begin
            r_bins[w_idx] <= w_bin_inc;
        end
    end

    // Hold the result until the consumer takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= n_out;
        end
    end

endmodule

### sv/latency_stats_histogram.sv
// Path: an accepted transaction is written into the two-entry work queue; when
//   the back end pops it, its result is registered in the output register.
// Throughput: one transaction per cycle while i_ready is high, set by the back-end
//   update (64-bit sum add, min/max compares, one bin counter increment).
// Reset: synchronous, active low; statistics return to their cleared values,
//   the work queue and output register are emptied.
// ----------------------------------------------------------------------------
// Latency statistics histogram
// Min/max/sum/count accumulator with a ten-bin fixed-edge histogram; front
// end classifies, a two-entry queue decouples, back end updates and reports.
// ----------------------------------------------------------------------------
`include "latency_stats_histogram_macros.svh"

module latency_stats_histogram (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  lsh_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output lsh_pkg::t_out o_data
);
    import lsh_pkg::*;

    logic    w_push;
    logic    w_pop;
    t_work   w_front_work;
    t_work   w_head_work;
    t_q_stat w_q_stat;
    logic    w_stats_live;
    logic    w_bin_live;

    // Classify incoming transactions
    lsh_front u_front (
        .i_in       (i_data),
        .i_in_valid (i_valid),
        .o_in_ready (o_ready),
        .i_q_stat   (w_q_stat),
        .o_push     (w_push),
        .o_work     (w_front_work)
    );

    // Decouple front and back ends
    lsh_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_work  (w_front_work),
        .i_pop   (w_pop),
        .o_work  (w_head_work),
        .o_stat  (w_q_stat)
    );

    // Update statistics and present results
    lsh_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_work      (w_head_work),
        .i_q_empty   (w_q_stat.empty),
        .o_pop       (w_pop),
        .o_out       (o_data),
        .o_out_valid (o_valid),
        .i_out_ready (i_ready)
    );

    // Qualify results that carry samples or a nonzero bin count
    assign w_stats_live = o_valid && (o_data.sample_count != 32'd0);
    assign w_bin_live   = o_valid && (o_data.bin_count != 32'd0);

    `LSH_ASSERT_IMPL(a_no_push_full, i_clk, i_rst_n, w_push, !w_q_stat.full)
    `LSH_ASSERT_IMPL(a_no_pop_empty, i_clk, i_rst_n, w_pop, !w_q_stat.empty)
    `LSH_ASSERT_IMPL(a_min_le_max, i_clk, i_rst_n, w_stats_live, o_data.min_value <= o_data.max_value)
    `LSH_ASSERT_IMPL(a_bin_in_range, i_clk, i_rst_n, w_bin_live, int'(o_data.bin_index) < NUM_BINS)

endmodule

### test/tb_latency_stats_histogram.sv
// ----------------------------------------------------------------------------
// Latency statistics histogram testbench
// Drives add, clear, read and unused commands through the valid/ready input,
// predicts each result from a local copy of the statistics and bins, and
// checks every result field in order while both sides idle and stall.
// ----------------------------------------------------------------------------
module tb_latency_stats_histogram;
    import lsh_pkg::*;

    // Upper bin edges of the first nine bins; the last bin takes the rest
    localparam logic [31:0] LAT_EDGE [0:8] = '{
        32'd50, 32'd100, 32'd200, 32'd500, 32'd1000, 32'd2000, 32'd5000,
        32'd20000, 32'd100000
    };
    localparam int RANDOM_ITEMS = 1630;
    localparam int HOLD_AFTER   = 500;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 20;

    typedef enum logic [1:0] {
        RX_FREE   = 2'd0,
        RX_COIN   = 2'd1,
        RX_THIRD  = 2'd2,
        RX_MOSTLY = 2'd3
    } t_rx_mode;

    logic i_clk;
    logic i_rst_n   = 1'b0;
    logic drv_valid = 1'b0;
    t_in  drv_data  = '0;
    logic rx_ready  = 1'b0;
    logic o_ready;
    logic o_valid;
    t_out o_data;

    // Stimulus and expectation stores
    t_in  stim_items [$];
    t_out expected_stats [$];

    // Predicted statistics state
    logic [31:0] st_count;
    logic [31:0] st_min;
    logic [31:0] st_max;
    logic [63:0] st_sum;
    logic [31:0] st_bins [NUM_BINS];

    // Driver, receiver and checker bookkeeping
    logic     in_accepted   = 1'b0;
    int       accepted_cnt  = 0;
    int       fail_count    = 0;
    int       gap_left      = 0;
    int       burst_left    = 1;
    int       hold_left     = 0;
    logic     hold_done     = 1'b0;
    t_rx_mode rx_mode       = RX_FREE;
    int       mode_left     = 0;
    int       rx_phase      = 0;

    latency_stats_histogram u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (drv_valid),
        .o_ready (o_ready),
        .i_data  (drv_data),
        .o_valid (o_valid),
        .i_ready (rx_ready),
        .o_data  (o_data)
    );

    // Restore the cleared statistics
    function automatic void clear_stats();
        st_count = '0;
        st_min   = '1;
        st_max   = '0;
        st_sum   = '0;
        for (int i = 0; i < NUM_BINS; i++) begin
            st_bins[i] = '0;
        end
    endfunction

    // First bin whose upper edge is at least the sample
    function automatic int bin_of(logic [31:0] s);
        int idx;
        idx = NUM_BINS - 1;
        for (int i = NUM_BINS - 2; i >= 0; i--) begin
            if (s <= LAT_EDGE[i]) begin
                idx = i;
            end
        end
        return idx;
    endfunction

    // Apply one command to the predicted state and return the expected result
    function automatic t_out predict_stats(t_in item);
        t_out res;
        int   idx;
        res.bin_index = '0;
        res.bin_count = '0;
        case (item.command)
            CMD_ADD: begin
                idx = bin_of(item.sample);
                st_count = st_count + 32'd1;
                st_sum   = st_sum + {32'd0, item.sample};
                if (item.sample < st_min) begin
                    st_min = item.sample;
                end
                if (item.sample > st_max) begin
                    st_max = item.sample;
                end
                st_bins[idx] = st_bins[idx] + 32'd1;
                res.bin_index = 4'(idx);
                res.bin_count = st_bins[idx];
            end
            CMD_CLEAR: begin
                clear_stats();
            end
            CMD_READ: begin
                res.bin_index = item.bin_select;
                if (int'(item.bin_select) < NUM_BINS) begin
                    res.bin_count = st_bins[item.bin_select];
                end
            end
            default: begin
            end
        endcase
        res.sample_count = st_count;
        res.min_value    = st_min;
        res.max_value    = st_max;
        res.sample_sum   = st_sum;
        return res;
    endfunction

    function automatic void queue_item(t_cmd c, logic [31:0] s, logic [3:0] b);
        t_in it;
        it.command    = c;
        it.sample     = s;
        it.bin_select = b;
        stim_items.push_back(it);
    endfunction

    function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t mismatch %s: expected %h actual %h", $time, name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Check results and record accepted transactions at the rising edge
    always @(posedge i_clk) begin
        t_out exp_r;
        if (!i_rst_n) begin
            in_accepted <= 1'b0;
        end else begin
            if (o_valid && rx_ready) begin
                if (expected_stats.size() == 0) begin
                    $display("%0t unexpected result: expected none actual %h", $time, o_data);
                    fail_count++;
                end else begin
                    exp_r = expected_stats.pop_front();
                    check_field("sample_count", 64'(exp_r.sample_count),
                                64'(o_data.sample_count));
                    check_field("min_value", 64'(exp_r.min_value), 64'(o_data.min_value));
                    check_field("max_value", 64'(exp_r.max_value), 64'(o_data.max_value));
                    check_field("sample_sum", exp_r.sample_sum, o_data.sample_sum);
                    check_field("bin_index", 64'(exp_r.bin_index), 64'(o_data.bin_index));
                    check_field("bin_count", 64'(exp_r.bin_count), 64'(o_data.bin_count));
                end
            end
            if (drv_valid && o_ready) begin
                expected_stats.push_back(predict_stats(drv_data));
                accepted_cnt <= accepted_cnt + 1;
            end
            in_accepted <= drv_valid && o_ready;
        end
    end

    // Sender: hold until accepted, then offer the next item in bursts with gaps
    always @(negedge i_clk) begin
        if (!i_rst_n || (drv_valid && !in_accepted)) begin
            // hold the current transaction
        end else if (gap_left != 0) begin
            gap_left  <= gap_left - 1;
            drv_valid <= 1'b0;
        end else if (stim_items.size() != 0) begin
            drv_data  <= stim_items.pop_front();
            drv_valid <= 1'b1;
            if (burst_left <= 1) begin
                burst_left <= $urandom_range(1, 60);
                gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
                burst_left <= burst_left - 1;
            end
        end else begin
            drv_valid <= 1'b0;
        end
    end

    // Receiver: switch stall patterns now and then, and hold off once for long
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rx_ready  <= 1'b0;
        end else if (!hold_done && accepted_cnt >= HOLD_AFTER) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            rx_ready  <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode   <= t_rx_mode'($urandom_range(0, 3));
                mode_left <= $urandom_range(30, 200);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (rx_mode)
                RX_FREE:   rx_ready <= 1'b1;
                RX_COIN:   rx_ready <= 1'($urandom_range(0, 1));
                RX_THIRD:  rx_ready <= (rx_phase % 3 == 0);
                default:   rx_ready <= ($urandom_range(0, 9) != 0);
            endcase
            rx_phase <= rx_phase + 1;
        end
    end

    // Build the stimulus, run, drain and report
    initial begin
        int          r;
        int          k;
        logic [31:0] s;
        logic [3:0]  b;

        clear_stats();

        // Directed: empty reads, every edge and the values just above 50, 100 and 100000,
        // out-of-range reads, the unused command, clear and restart
        queue_item(CMD_READ, 32'hFFFF_FFFF, 4'd0);
        queue_item(CMD_NONE, 32'h0, 4'hF);
        queue_item(CMD_ADD, 32'd0, 4'd0);
        queue_item(CMD_ADD, 32'd50, 4'hF);
        queue_item(CMD_ADD, 32'd51, 4'd0);
        queue_item(CMD_ADD, 32'd100, 4'd0);
        queue_item(CMD_ADD, 32'd101, 4'd0);
        queue_item(CMD_ADD, 32'd200, 4'd0);
        queue_item(CMD_ADD, 32'd500, 4'd0);
        queue_item(CMD_ADD, 32'd1000, 4'd0);
        queue_item(CMD_ADD, 32'd2000, 4'd0);
        queue_item(CMD_ADD, 32'd5000, 4'd0);
        queue_item(CMD_ADD, 32'd20000, 4'd0);
        queue_item(CMD_ADD, 32'd100000, 4'd0);
        queue_item(CMD_ADD, 32'd100001, 4'd0);
        queue_item(CMD_ADD, 32'hFFFF_FFFF, 4'd0);
        queue_item(CMD_READ, 32'd0, 4'd9);
        queue_item(CMD_READ, 32'd0, 4'd15);
        queue_item(CMD_READ, 32'd0, 4'd10);
        queue_item(CMD_READ, 32'd0, 4'd3);
        queue_item(CMD_CLEAR, 32'hFFFF_FFFF, 4'hF);
        queue_item(CMD_READ, 32'd0, 4'd9);
        queue_item(CMD_ADD, 32'd7, 4'd0);
        queue_item(CMD_NONE, 32'hFFFF_FFFF, 4'd0);

        // Random: mostly adds that build up statistics, with reads, rare clears
        // and unused commands; unused fields carry random bits
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            r = $urandom_range(0, 99);
            b = 4'($urandom);
            s = $urandom;
            if (r < 70) begin
                case ($urandom_range(0, 5))
                    0: s = $urandom;
                    1: begin
                        k = $urandom_range(0, 8);
                        s = LAT_EDGE[k] + $urandom_range(0, 2) - 1;
                    end
                    2: s = $urandom_range(0, 300);
                    3: s = $urandom_range(0, 150000);
                    4: s = ($urandom_range(0, 1) == 0) ? 32'd0 : 32'hFFFF_FFFF;
                    default: s = $urandom >> $urandom_range(0, 31);
                endcase
                queue_item(CMD_ADD, s, b);
            end else if (r < 94) begin
                if ($urandom_range(0, 4) != 0) begin
                    b = 4'($urandom_range(0, NUM_BINS - 1));
                end
                queue_item(CMD_READ, s, b);
            end else if (r < 96) begin
                queue_item(CMD_CLEAR, s, b);
            end else begin
                queue_item(CMD_NONE, s, b);
            end
        end

        // Hold reset while the clock runs, then release it at a falling edge
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Wait until every item is accepted and every result has arrived
        while (stim_items.size() != 0 || drv_valid) begin
            @(posedge i_clk);
        end
        while (expected_stats.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("status: fail");
        $finish;
    end

endmodule
